// File: hdl/lkx_pkg.sv
`default_nettype none

package lkx_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned ModW         = 31;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CfgIdxW      = 8;
  localparam int unsigned DivBitsPerStep = 2;
  localparam int unsigned DivSteps     = WordW / DivBitsPerStep;
  localparam int unsigned DivCntW      = $clog2(DivSteps);

  localparam logic [WordW-1:0] SeedReset      = '0;
  localparam logic [WordW-1:0] MultiplierReset = WordW'(1);
  localparam logic [WordW-1:0] IncrementReset = '0;
  localparam logic [ModW-1:0]  ModulusReset   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED       = CfgIdxW'(0),
    REG_MULTIPLIER = CfgIdxW'(1),
    REG_INCREMENT  = CfgIdxW'(2),
    REG_MODULUS    = CfgIdxW'(3)
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic       load_seed;
    logic       load_next;
    logic [1:0] byte_sel;
    logic       mul;
    logic       add;
    logic       div_step;
    logic       fix;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_zero;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/lkx_in_if.sv
`default_nettype none

interface lkx_in_if
  import lkx_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] plain_byte;
  logic             last_byte;

  modport source (output valid, output plain_byte, output last_byte, input ready);
  modport sink   (input valid, input plain_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/lkx_out_if.sv
`default_nettype none

interface lkx_out_if
  import lkx_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cipher_byte;
  logic             last_out;

  modport source (output valid, output cipher_byte, output last_out, input ready);
  modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

`default_nettype wire

// File: hdl/lkx_cfg_if.sv
`default_nettype none

interface lkx_cfg_if
  import lkx_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/lkx_datapath.sv
`default_nettype none

module lkx_datapath
  import lkx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic [ByteW-1:0]   plain_byte_i,
  input  wire logic               last_byte_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic [ByteW-1:0]        cipher_byte_o,
  output logic                    last_out_o
);

  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] mult_q;
  logic [WordW-1:0] incr_q;
  logic [ModW-1:0]  mod_q;

  logic [WordW-1:0] key_q;
  logic [WordW-1:0] next_q;
  logic [WordW-1:0] prod_q;
  logic [WordW-1:0] dividend_q;
  logic [ModW-1:0]  rem_q;
  logic             neg_q;
  logic [ByteW-1:0] cipher_q;
  logic             last_q;

  logic [WordW-1:0] sum;
  logic [WordW-1:0] sum_abs;
  logic [ByteW-1:0] key_byte;
  logic [ModW-1:0]  rem_d;
  logic [WordW-1:0] dividend_d;
  logic [WordW-1:0] rem_fixed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      mult_q <= MultiplierReset;
      incr_q <= IncrementReset;
      mod_q  <= ModulusReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEED:       seed_q <= cfg_data_i;
        REG_MULTIPLIER: mult_q <= cfg_data_i;
        REG_INCREMENT:  incr_q <= cfg_data_i;
        REG_MODULUS:    mod_q  <= cfg_data_i[ModW-1:0];
        default: ;
      endcase
    end
  end

  assign status_o.mod_zero = (mod_q == '0);

  always_comb begin
    if (cmd_i.load_seed) begin
      key_byte = seed_q[ByteW-1:0];
    end else begin
      key_byte = key_q[ByteW*cmd_i.byte_sel +: ByteW];
    end
  end

  assign sum     = prod_q + incr_q;
  assign sum_abs = sum[WordW-1] ? (~sum + WordW'(1)) : sum;

  // restoring remainder, two dividend bits per step
  always_comb begin
    logic [ModW:0]    trial;
    logic [ModW-1:0]  r;
    logic [WordW-1:0] d;
    r = rem_q;
    d = dividend_q;
    for (int i = 0; i < DivBitsPerStep; i++) begin
      trial = {r, d[WordW-1]};
      d     = {d[WordW-2:0], 1'b0};
      if (trial >= {1'b0, mod_q}) begin
        trial = trial - {1'b0, mod_q};
      end
      r = trial[ModW-1:0];
    end
    rem_d      = r;
    dividend_d = d;
  end

  // remainder takes the sign of the dividend
  assign rem_fixed = neg_q ? (~{1'b0, rem_q} + WordW'(1)) : {1'b0, rem_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cipher_q <= plain_byte_i ^ key_byte;
      last_q   <= last_byte_i;
    end
    if (cmd_i.load_seed) begin
      key_q <= seed_q;
    end else if (cmd_i.load_next) begin
      key_q <= next_q;
    end
    if (cmd_i.mul) begin
      prod_q <= WordW'(mult_q * key_q);
    end
    if (cmd_i.add) begin
      next_q     <= sum;
      dividend_q <= sum_abs;
      neg_q      <= sum[WordW-1];
      rem_q      <= '0;
    end
    if (cmd_i.div_step) begin
      dividend_q <= dividend_d;
      rem_q      <= rem_d;
    end
    if (cmd_i.fix) begin
      next_q <= rem_fixed;
    end
  end

  assign cipher_byte_o = cipher_q;
  assign last_out_o    = last_q;

endmodule

`default_nettype wire

// File: hdl/lkx_ctrl.sv
`default_nettype none

module lkx_ctrl
  import lkx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  input  wire logic    cfg_we_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    GEN_IDLE = 6'b000001,
    GEN_MUL  = 6'b000010,
    GEN_ADD  = 6'b000100,
    GEN_DIV  = 6'b001000,
    GEN_FIX  = 6'b010000,
    GEN_DONE = 6'b100000
  } gen_state_e;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  gen_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [1:0]         pos_q, pos_d;
  logic               fresh_q, fresh_d;
  logic               out_valid_q, out_valid_d;

  logic out_free;
  logic word_ok;
  logic accept;
  logic word_end;
  logic restart;

  assign out_free   = !out_valid_q || out_ready_i;
  assign word_end   = !fresh_q && (pos_q == 2'd3);
  assign word_ok    = !word_end || (state_q == GEN_DONE);
  assign in_ready_o = out_free && word_ok;
  assign accept     = in_valid_i && in_ready_o;
  // new key word or changed coefficients: generate the following word again
  assign restart    = cfg_we_i || (accept && (fresh_q || word_end));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      GEN_MUL: state_d = GEN_ADD;
      GEN_ADD: begin
        cnt_d   = '0;
        state_d = status_i.mod_zero ? GEN_DONE : GEN_DIV;
      end
      GEN_DIV: begin
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivLast) begin
          state_d = GEN_FIX;
        end
      end
      GEN_FIX:  state_d = GEN_DONE;
      GEN_DONE: state_d = GEN_DONE;
      GEN_IDLE: state_d = GEN_IDLE;
      default:  state_d = GEN_IDLE;
    endcase
    if (restart) begin
      state_d = GEN_MUL;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      pos_d       = fresh_q ? 2'd1 : pos_q + 2'd1;
      fresh_d     = in_last_i;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= GEN_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.load_seed = accept && fresh_q;
    cmd_o.load_next = accept && word_end;
    cmd_o.byte_sel  = fresh_q ? 2'd0 : pos_q;
    cmd_o.mul       = (state_q == GEN_MUL);
    cmd_o.add       = (state_q == GEN_ADD);
    cmd_o.div_step  = (state_q == GEN_DIV);
    cmd_o.fix       = (state_q == GEN_FIX);
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/lcg_keystream_xor_cipher_top.sv
// LCG keystream XOR cipher.
// in_ch carries plain_byte and last_byte; out_ch returns cipher_byte (input
// XOR the current keystream byte, low byte of the word first) and last_out.
// cfg_ch writes seed (0), multiplier (1), increment (2) and modulus (3);
// other indices are ignored. cfg_ch is always ready; write only while idle.
// A result is shown in the cycle after its input transaction.
// While the receiver keeps up, one byte per cycle for the first three bytes
// of a key word. The fourth byte waits until the next word is ready: a
// multiply step, an add step, the remainder steps (two bits each) and a
// sign-fix step, all started as soon as the current word is loaded. With a
// zero modulus the remainder and sign-fix steps are skipped and bytes flow
// one per cycle while the receiver keeps up. A register write restarts the
// word generation. A byte after one flagged last starts again from the
// seed with no wait.
// Reset loads the register defaults and arms the next byte to use the seed.
// While the receiver stalls, the result is held and a new byte is taken
// only in the cycle where the held result leaves.
`default_nettype none

module lcg_keystream_xor_cipher_top
  import lkx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lkx_in_if.sink    in_ch,
  lkx_out_if.source out_ch,
  lkx_cfg_if.sink   cfg_ch
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  lkx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last_byte),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .cfg_we_i    (cfg_we),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lkx_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_ch.index),
    .cfg_data_i    (cfg_ch.data),
    .plain_byte_i  (in_ch.plain_byte),
    .last_byte_i   (in_ch.last_byte),
    .cmd_i         (cmd),
    .status_o      (status),
    .cipher_byte_o (out_ch.cipher_byte),
    .last_out_o    (out_ch.last_out)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("input transaction without result");

  a_ready_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input ready while result slot is held");

  a_key_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load_seed && cmd.load_next))
    else $error("key word loaded from seed and generator together");

  a_mul_then_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul && !cfg_ch.valid && !(in_ch.valid && in_ch.ready) |=> cmd.add)
    else $error("generator skipped the add step");
`endif

endmodule

`default_nettype wire
